FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the neuron RTL file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication on the rising clock edge, masked during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication on the rising clock edge, masked during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hdl/tnbp_pkg.sv
// ---------------------------------------------------------------------------
// tnbp_pkg
// Types, codes, fixed-point constants and the tanh table builder.
// ---------------------------------------------------------------------------
`default_nettype none

package tnbp_pkg;

   localparam int FRAC_BITS   = 12;
   localparam int TANH_DEPTH  = 256;
   localparam int TANH_AW     = $clog2(TANH_DEPTH);
   localparam int VALUE_W     = 16;
   localparam int INDEX_W     = 6;
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [2:0] {
      CMD_FORWARD = 3'd0,
      CMD_TARGET  = 3'd1,
      CMD_HIDDEN  = 3'd2,
      CMD_UPDATE  = 3'd3,
      CMD_LOAD    = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_OUTPUT   = 2'd0,
      KIND_GRADIENT = 2'd1,
      KIND_WEIGHT   = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LEARNING_RATE = 2'd0,
      CSR_MOMENTUM      = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic                       flag;
      logic signed [VALUE_W-1:0]  value;
   } sat_type;

   typedef logic signed [VALUE_W-1:0] tanh_lut_type [TANH_DEPTH];

   // Clip a wide value to the signed 16-bit range and flag it.
   function automatic sat_type sat16(input logic signed [63:0] x);
      sat_type r;
      if (x < -64'sd32768) begin
         r.flag  = 1'b1;
         r.value = -16'sd32768;
      end else if (x > 64'sd32767) begin
         r.flag  = 1'b1;
         r.value = 16'sd32767;
      end else begin
         r.flag  = 1'b0;
         r.value = x[VALUE_W-1:0];
      end
      return r;
   endfunction

   // Unsigned quotient by restoring shift and subtract, for table building.
   function automatic longint unsigned udiv64(input longint unsigned n,
                                              input longint unsigned d);
      longint unsigned q, r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], n[b]};
         if (r >= d) begin
            r    = r - d;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // One tanh sample at the center of bin i over [-4, 4).
   function automatic logic signed [VALUE_W-1:0] tanh_sample(input int i);
      longint          m;
      longint unsigned a, u, u2, u3, u4, e, num, den, q;
      longint unsigned one;
      one = 64'd1 << 30;
      m   = 2 * i + 1 - TANH_DEPTH;
      a   = (m < 0) ? longint'(-m) : longint'(m);
      u   = (a << 30) >> (5 + TANH_AW);
      u2  = (u * u) >> 30;
      u3  = (u2 * u) >> 30;
      u4  = (u3 * u) >> 30;
      e   = one - u + (u2 >> 1) - udiv64(u3, 64'd6) + udiv64(u4, 64'd24);
      for (int k = 0; k < 8; k++) begin
         e = (e * e) >> 30;
      end
      num = (one - e) << FRAC_BITS;
      den = one + e;
      q   = udiv64(num + (den >> 1), den);
      return (m < 0) ? VALUE_W'(-longint'(q)) : VALUE_W'(q);
   endfunction

   // Build the whole table at elaboration.
   function automatic tanh_lut_type tanh_build();
      tanh_lut_type t;
      for (int i = 0; i < TANH_DEPTH; i++) begin
         t[i] = tanh_sample(i);
      end
      return t;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/tnbp_req_if.sv
// ---------------------------------------------------------------------------
// tnbp_req_if
// Command channel: valid, ready and one command item.
// ---------------------------------------------------------------------------
`default_nettype none

interface tnbp_req_if;
   logic                                valid;
   logic                                ready;
   logic [2:0]                          cmd;
   logic [tnbp_pkg::INDEX_W-1:0]        element_index;
   logic signed [tnbp_pkg::VALUE_W-1:0] value;
   logic signed [tnbp_pkg::VALUE_W-1:0] link_weight;
   logic                                last;

   modport source (output valid, cmd, element_index, value, link_weight, last,
                   input ready);
   modport sink   (input valid, cmd, element_index, value, link_weight, last,
                   output ready);
endinterface

`default_nettype wire

FILE: hdl/tnbp_rsp_if.sv
// ---------------------------------------------------------------------------
// tnbp_rsp_if
// Result channel: valid, ready and one result item.
// ---------------------------------------------------------------------------
`default_nettype none

interface tnbp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          kind;
   logic signed [tnbp_pkg::VALUE_W-1:0] result_value;
   logic [tnbp_pkg::INDEX_W-1:0]        result_index;
   logic                                saturated;

   modport source (output valid, kind, result_value, result_index, saturated,
                   input ready);
   modport sink   (input valid, kind, result_value, result_index, saturated,
                   output ready);
endinterface

`default_nettype wire

FILE: hdl/tnbp_csr_if.sv
// ---------------------------------------------------------------------------
// tnbp_csr_if
// Register write channel: valid, ready, register index and data.
// ---------------------------------------------------------------------------
`default_nettype none

interface tnbp_csr_if;
   logic                              valid;
   logic                              ready;
   logic [tnbp_pkg::CSR_INDEX_W-1:0]  index;
   logic [15:0]                       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/tnbp_tanh_lut.sv
// ---------------------------------------------------------------------------
// tnbp_tanh_lut
// Clamp the sum to [-4, 4), pick a bin and read tanh from a constant table.
// ---------------------------------------------------------------------------
`default_nettype none

module tnbp_tanh_lut (
   input  wire logic signed [31:0]                   sum,
   output logic signed [tnbp_pkg::VALUE_W-1:0]       tanh_value
);
   import tnbp_pkg::*;

   localparam tanh_lut_type LUT = tanh_build();
   localparam logic signed [31:0] LIM = 32'sd4 <<< FRAC_BITS;

   logic signed [31:0] clamped;
   logic [31:0]        offset;
   logic [31:0]        bin;

   // Clamp, shift to non-negative and scale to a bin number
   always_comb begin
      if (sum < -LIM) begin
         clamped = -LIM;
      end else if (sum > LIM - 32'sd1) begin
         clamped = LIM - 32'sd1;
      end else begin
         clamped = sum;
      end
      offset = 32'(clamped + LIM);
      bin    = (offset * 32'(TANH_DEPTH)) >> (FRAC_BITS + 3);
   end

   assign tanh_value = LUT[bin[TANH_AW-1:0]];

endmodule

`default_nettype wire

FILE: hdl/tanh_neuron_backprop_unit.sv
// ---------------------------------------------------------------------------
// tanh_neuron_backprop_unit
// One tanh neuron with weight storage, backpropagation and momentum update.
// ---------------------------------------------------------------------------
//  channel  | dir | transfer when          | payload
//  req_ch   | in  | valid & ready          | cmd, element_index, value, link_weight, last
//  rsp_ch   | out | valid & ready          | kind, result_value, result_index, saturated
//  csr_ch   | in  | valid (ready always 1) | index, data
//
//  Each command passes through a memory read, three multiply stages
//  and a write-back stage; the weight and delta memories each have one port.
//  After reset the delta memory is zeroed entry by entry, with req_ch
//  not ready; csr writes are taken throughout.
//  A result held in the output register stalls write-back and keeps req_ch not ready.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tanh_neuron_backprop_unit #(
   parameter int NUM_INPUTS = 64
) (
   input  wire logic   clock,
   input  wire logic   reset,
   tnbp_req_if.sink    req_ch,
   tnbp_rsp_if.source  rsp_ch,
   tnbp_csr_if.sink    csr_ch
);
   import tnbp_pkg::*;

   localparam int AW = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
   localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;
   localparam logic signed [18:0] DERIV_ONE = 19'sd1 <<< FRAC_BITS;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_MUL1  = 6'b000100,
      ST_MUL2  = 6'b001000,
      ST_MUL3  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;

   logic signed [VALUE_W-1:0] weight_mem [NUM_INPUTS];
   logic signed [VALUE_W-1:0] delta_mem  [NUM_INPUTS];
   logic signed [VALUE_W-1:0] w_rd_ff, d_rd_ff;

   logic [15:0] eta_ff, alpha_ff;

   logic [2:0]                cmd_ff;
   logic [INDEX_W-1:0]        idx_ff;
   logic signed [VALUE_W-1:0] val_ff, link_ff;
   logic                      last_ff, ok_ff;

   logic signed [31:0]        acc_ff, acc_in;
   logic signed [VALUE_W-1:0] out_ff, out_in;
   logic signed [VALUE_W-1:0] grad_ff, grad_in;

   logic signed [33:0] p1_ff, p1_in;
   logic signed [32:0] q1_ff, q1_in;
   logic signed [49:0] p2_ff, p2_in;
   logic signed [50:0] p3_ff, p3_in;

   logic                      rsp_valid_ff;
   logic [1:0]                kind_ff;
   logic signed [VALUE_W-1:0] res_ff;
   logic [INDEX_W-1:0]        ridx_ff;
   logic                      sat_ff;

   logic                      accept, ok_in, done_go, emit;
   logic [IW-1:0]             idx_ext;
   logic [AW-1:0]             rd_addr, wr_addr;
   logic signed [VALUE_W-1:0] tanh_value;
   logic signed [32:0]        acc_sum;
   logic signed [18:0]        deriv;
   logic signed [16:0]        diff;
   sat_type                   g_sat, d_sat, w_sat;
   logic                      w_we, d_we;
   logic signed [VALUE_W-1:0] w_wd;
   logic [1:0]                kind_in;
   logic signed [VALUE_W-1:0] res_in;
   logic [INDEX_W-1:0]        ridx_in;
   logic                      sat_in;

   assign accept    = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign idx_ext   = IW'(req_ch.element_index);
   assign rd_addr   = idx_ext[AW-1:0];
   assign ok_in     = {{(32-INDEX_W){1'b0}}, req_ch.element_index} < 32'(NUM_INPUTS);
   assign done_go   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   // Hold the configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         eta_ff   <= 16'd9830;
         alpha_ff <= 16'd6554;
      end else if (csr_ch.valid) begin
         priority if (csr_ch.index == CSR_LEARNING_RATE) begin
            eta_ff <= csr_ch.data;
         end else if (csr_ch.index == CSR_MOMENTUM) begin
            alpha_ff <= csr_ch.data;
         end
      end
   end

   // Sequence the stages
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(NUM_INPUTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE:  if (accept) state_in = ST_MUL1;
         ST_MUL1:  state_in = ST_MUL2;
         ST_MUL2:  state_in = ST_MUL3;
         ST_MUL3:  state_in = ST_DONE;
         ST_DONE:  if (done_go) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // Capture the command on transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_ch.cmd;
         idx_ff  <= req_ch.element_index;
         val_ff  <= req_ch.value;
         link_ff <= req_ch.link_weight;
         last_ff <= req_ch.last;
         ok_ff   <= ok_in;
      end
   end

   // Weight and delta memories: read on transfer, write at the last stage or while clearing
   assign wr_addr = (state_ff == ST_CLEAR) ? clr_ff : idx_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (w_we) begin
         weight_mem[wr_addr] <= w_wd;
      end
      if (accept) begin
         w_rd_ff <= weight_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (d_we) begin
         delta_mem[wr_addr] <= (state_ff == ST_CLEAR) ? '0 : d_sat.value;
      end
      if (accept) begin
         d_rd_ff <= delta_mem[rd_addr];
      end
   end

   // First multiply: element product, or rate times input and momentum term
   always_comb begin
      p1_in = '0;
      q1_in = 33'(signed'({1'b0, alpha_ff})) * 33'(d_rd_ff);
      unique case (cmd_ff)
         CMD_FORWARD: p1_in = 34'(val_ff) * 34'(ok_ff ? w_rd_ff : 16'sd0);
         CMD_HIDDEN:  p1_in = 34'(link_ff) * 34'(val_ff);
         CMD_UPDATE:  p1_in = 34'(signed'({1'b0, eta_ff})) * 34'(val_ff);
         default:     p1_in = '0;
      endcase
   end

   // Second multiply: gradient term or output squared; also accumulate
   always_comb begin
      acc_sum = 33'(acc_ff) + 33'(p1_ff >>> FRAC_BITS);
      if (cmd_ff == CMD_UPDATE) begin
         p2_in = 50'(p1_ff) * 50'(grad_ff);
      end else begin
         p2_in = 50'(out_ff) * 50'(out_ff);
      end
   end

   // Third multiply: gradient product, or sum of the update terms
   always_comb begin
      deriv = DERIV_ONE - 19'(p2_ff >>> FRAC_BITS);
      diff  = 17'(val_ff) - 17'(out_ff);
      unique case (cmd_ff)
         CMD_TARGET: p3_in = 51'(diff) * 51'(deriv);
         CMD_HIDDEN: p3_in = 51'(acc_ff) * 51'(deriv);
         CMD_UPDATE: p3_in = 51'(p2_ff) + (51'(q1_ff) <<< FRAC_BITS);
         default:    p3_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_MUL1) begin
         p1_ff <= p1_in;
         q1_ff <= q1_in;
      end
      if (state_ff == ST_MUL2) begin
         p2_ff <= p2_in;
      end
      if (state_ff == ST_MUL3) begin
         p3_ff <= p3_in;
      end
   end

   tnbp_tanh_lut u_tanh (
      .sum        (acc_ff),
      .tanh_value (tanh_value)
   );

   // Write back: neuron state, memories and the result
   always_comb begin
      g_sat   = sat16(64'(p3_ff >>> FRAC_BITS));
      d_sat   = sat16(64'(p3_ff >>> (16 + FRAC_BITS)));
      w_sat   = sat16(64'(17'(w_rd_ff) + 17'(d_sat.value)));
      acc_in  = acc_ff;
      out_in  = out_ff;
      grad_in = grad_ff;
      w_we    = 1'b0;
      d_we    = (state_ff == ST_CLEAR);
      w_wd    = w_sat.value;
      emit    = 1'b0;
      kind_in = KIND_OUTPUT;
      res_in  = '0;
      ridx_in = '0;
      sat_in  = 1'b0;
      if (state_ff == ST_MUL2 && (cmd_ff == CMD_FORWARD || cmd_ff == CMD_HIDDEN)) begin
         if (acc_sum > 33'sh0_7FFF_FFFF) begin
            acc_in = 32'sh7FFF_FFFF;
         end else if (acc_sum < -33'sh0_8000_0000) begin
            acc_in = 32'sh8000_0000;
         end else begin
            acc_in = acc_sum[31:0];
         end
      end
      if (done_go) begin
         unique case (cmd_ff)
            CMD_FORWARD: if (last_ff) begin
               out_in  = tanh_value;
               acc_in  = '0;
               emit    = 1'b1;
               kind_in = KIND_OUTPUT;
               res_in  = tanh_value;
            end
            CMD_TARGET: begin
               grad_in = g_sat.value;
               emit    = 1'b1;
               kind_in = KIND_GRADIENT;
               res_in  = g_sat.value;
               sat_in  = g_sat.flag;
            end
            CMD_HIDDEN: if (last_ff) begin
               grad_in = g_sat.value;
               acc_in  = '0;
               emit    = 1'b1;
               kind_in = KIND_GRADIENT;
               res_in  = g_sat.value;
               sat_in  = g_sat.flag;
            end
            CMD_UPDATE: begin
               emit    = 1'b1;
               kind_in = KIND_WEIGHT;
               ridx_in = idx_ff;
               if (ok_ff) begin
                  w_we   = 1'b1;
                  d_we   = 1'b1;
                  res_in = w_sat.value;
                  sat_in = d_sat.flag || w_sat.flag;
               end
            end
            CMD_LOAD: begin
               w_we = ok_ff;
               w_wd = val_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         out_ff  <= '0;
         grad_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         out_ff  <= out_in;
         grad_ff <= grad_in;
      end
   end

   // Output register: load on emit, drop valid on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff <= kind_in;
         res_ff  <= res_in;
         ridx_ff <= ridx_in;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.kind         = kind_ff;
   assign rsp_ch.result_value = res_ff;
   assign rsp_ch.result_index = ridx_ff;
   assign rsp_ch.saturated    = sat_ff;

   // Checks
   `ASSERT_SAME(a_clear_blocks, clock, reset, state_ff == ST_CLEAR, !req_ch.ready)
   `ASSERT_NEXT(a_accept_starts, clock, reset, accept, state_ff == ST_MUL1)
   `ASSERT_NEXT(a_stall_holds, clock, reset,
      state_ff == ST_DONE && rsp_valid_ff && !rsp_ch.ready, state_ff == ST_DONE)

endmodule

`default_nettype wire

FILE: tb/tanh_neuron_backprop_unit_tb.sv
// ---------------------------------------------------------------------------
// tanh_neuron_backprop_unit_tb
// Drives command transfers into the neuron, predicts each result from its
// own copy of weights, deltas, accumulator and rates, and checks every
// result transfer in order. Runs several idle/stall phases and rate settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

import tnbp_pkg::*;

typedef struct packed {
   logic [1:0]         kind;
   logic signed [15:0] value;
   logic [5:0]         index;
   logic               sat;
} neuron_result_type;

class neuron_scoreboard;
   longint         wt [64];
   longint         dw [64];
   longint         acc, nout, grad;
   longint unsigned eta, alpha;
   logic signed [15:0] lut [TANH_DEPTH];
   neuron_result_type pending [$];
   int             errors;

   function new();
      longint m, a, u, u2, u3, u4, e, num, den, q;
      for (int i = 0; i < 64; i++) begin
         wt[i] = 0;
         dw[i] = 0;
      end
      acc = 0; nout = 0; grad = 0; eta = 9830; alpha = 6554; errors = 0;
      // build the tanh samples with the Q30 exponential
      for (int i = 0; i < TANH_DEPTH; i++) begin
         m = 2 * i + 1 - TANH_DEPTH;
         a = (m < 0) ? -m : m;
         u = (a <<< 30) / (32 * TANH_DEPTH);
         u2 = (u * u) >>> 30; u3 = (u2 * u) >>> 30; u4 = (u3 * u) >>> 30;
         e = (64'sd1 <<< 30) - u + u2 / 2 - u3 / 6 + u4 / 24;
         for (int k = 0; k < 8; k++) e = (e * e) >>> 30;
         num = ((64'sd1 <<< 30) - e) <<< FRAC_BITS;
         den = (64'sd1 <<< 30) + e;
         q = (num + den / 2) / den;
         lut[i] = 16'((m < 0) ? -q : q);
      end
   endfunction

   function longint clamp(longint x, longint lo, longint hi, ref bit f);
      if (x < lo) begin f = 1; return lo; end
      if (x > hi) begin f = 1; return hi; end
      return x;
   endfunction

   function void add_product(longint p, longint q);
      bit f;
      acc = clamp(acc + ((p * q) >>> FRAC_BITS), -64'sd2147483648, 64'sd2147483647, f);
   endfunction

   // append one expected result at the tail
   function void expect_result(neuron_result_type r);
      pending.insert(pending.size(), r);
   endfunction

   // note one accepted command and queue its expected result
   function void note_command(logic [2:0] cmd, logic [5:0] idx, logic signed [15:0] v,
                              logic signed [15:0] lw, logic lst);
      neuron_result_type r;
      bit      f;
      longint  s, t, d, w, deriv;
      f = 0;
      deriv = (64'sd1 <<< FRAC_BITS) - ((nout * nout) >>> FRAC_BITS);
      r.index = '0;
      r.sat = 0;
      case (cmd)
         CMD_FORWARD: begin
            add_product(v, wt[idx]);
            if (lst) begin
               s = clamp(acc, -(64'sd4 <<< FRAC_BITS), (64'sd4 <<< FRAC_BITS) - 1, f);
               t = ((s + (64'sd4 <<< FRAC_BITS)) * TANH_DEPTH) >>> (FRAC_BITS + 3);
               if (t >= TANH_DEPTH) t = TANH_DEPTH - 1;
               nout = lut[t];
               acc = 0;
               r.kind = KIND_OUTPUT; r.value = 16'(nout);
               expect_result(r);
            end
         end
         CMD_TARGET: begin
            grad = clamp(((longint'(v) - nout) * deriv) >>> FRAC_BITS, -32768, 32767, f);
            r.kind = KIND_GRADIENT; r.value = 16'(grad); r.sat = f;
            expect_result(r);
         end
         CMD_HIDDEN: begin
            add_product(lw, v);
            if (lst) begin
               grad = clamp((acc * deriv) >>> FRAC_BITS, -32768, 32767, f);
               acc = 0;
               r.kind = KIND_GRADIENT; r.value = 16'(grad); r.sat = f;
               expect_result(r);
            end
         end
         CMD_UPDATE: begin
            t = longint'(eta) * v * grad + (64'sd1 <<< FRAC_BITS) * longint'(alpha) * dw[idx];
            d = clamp(t >>> (16 + FRAC_BITS), -32768, 32767, f);
            w = clamp(wt[idx] + d, -32768, 32767, f);
            dw[idx] = d;
            wt[idx] = w;
            r.kind = KIND_WEIGHT; r.value = 16'(w); r.index = idx; r.sat = f;
            expect_result(r);
         end
         CMD_LOAD: wt[idx] = v;
         default: ;
      endcase
   endfunction

   // compare one result transfer with the oldest expectation
   function void check_result(neuron_result_type got);
      neuron_result_type exp_r;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result kind=%0d value=%0d", $time, got.kind, got.value);
         errors++;
         return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
         $display("%0t: mismatch expected kind=%0d value=%0d index=%0d sat=%0d",
                  $time, exp_r.kind, exp_r.value, exp_r.index, exp_r.sat);
         $display("%0t:          actual   kind=%0d value=%0d index=%0d sat=%0d",
                  $time, got.kind, got.value, got.index, got.sat);
         errors++;
      end
   endfunction
endclass

module tanh_neuron_backprop_unit_tb;
   logic clock;
   logic reset;
   tnbp_req_if req_ch ();
   tnbp_rsp_if rsp_ch ();
   tnbp_csr_if csr_ch ();

   tanh_neuron_backprop_unit dut (
      .clock (clock), .reset (reset),
      .req_ch (req_ch.sink), .rsp_ch (rsp_ch.source), .csr_ch (csr_ch.sink)
   );

   neuron_scoreboard board;
   int  send_idle_pct;
   int  stall_pct;
   longint cycles;
   bit  loaded [64];

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > 400000) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // receiver: stall at random, check each transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_result({rsp_ch.kind, rsp_ch.result_value, rsp_ch.result_index,
                                rsp_ch.saturated});
         rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // send one command, holding it until transferred
   task automatic send_command(logic [2:0] cmd, logic [5:0] idx, logic [15:0] v,
                               logic [15:0] lw, logic lst);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= cmd;
      req_ch.element_index <= idx;
      req_ch.value <= v;
      req_ch.link_weight <= lw;
      req_ch.last <= lst;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_command(cmd, idx, v, lw, lst);
      if (cmd == CMD_LOAD) loaded[idx] = 1;
   endtask

   task automatic release_request();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait for all results and the pipeline to drain, then write a register
   task automatic write_register(csr_index_type which, logic [15:0] data);
      release_request();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= which;
      csr_ch.data <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      if (which == CSR_LEARNING_RATE) board.eta = data; else board.alpha = data;
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(8191) - 4096);
         default: return 16'($urandom);
      endcase
   endfunction

   // forward pass over n elements, then target or hidden gradient, then updates
   task automatic training_step(int n);
      int base;
      base = $urandom_range(63 - n);
      for (int i = 0; i < n; i++)
         send_command(CMD_FORWARD, 6'(base + i), pick_value(), 16'($urandom), i == n - 1);
      if ($urandom_range(1))
         send_command(CMD_TARGET, 6'($urandom), pick_value(), 16'($urandom),
                      1'($urandom));
      else
         for (int i = 0; i < n; i++)
            send_command(CMD_HIDDEN, 6'($urandom), pick_value(), pick_value(), i == n - 1);
      for (int i = 0; i < n; i++)
         send_command(CMD_UPDATE, 6'(base + i), pick_value(), 16'($urandom), 1'($urandom));
   endtask

   task automatic random_command();
      logic [2:0] cmd;
      logic [5:0] idx;
      cmd = 3'($urandom_range(7));
      idx = 6'($urandom);
      // never read a weight that was not loaded
      if ((cmd == CMD_FORWARD || cmd == CMD_UPDATE) && !loaded[idx]) cmd = CMD_LOAD;
      send_command(cmd, idx, pick_value(), pick_value(), 1'($urandom));
   endtask

   int phase_idle [4] = '{0, 54, 0, 28};
   int phase_stall [4] = '{0, 0, 54, 28};
   logic [15:0] rates [4] = '{16'hffff, 16'h0000, 16'd9830, 16'd40000};
   logic [15:0] moms [4] = '{16'hffff, 16'h0000, 16'd6554, 16'd20000};

   initial begin
      board = new();
      reset = 1'b1;
      req_ch.valid = 1'b0; req_ch.cmd = '0; req_ch.element_index = '0;
      req_ch.value = '0; req_ch.link_weight = '0; req_ch.last = 1'b0;
      csr_ch.valid = 1'b0; csr_ch.index = CSR_LEARNING_RATE; csr_ch.data = '0;
      send_idle_pct = 0; stall_pct = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: load every weight, extremes, every operation
      for (int i = 0; i < 64; i++)
         send_command(CMD_LOAD, 6'(i),
                      (i == 0) ? 16'h8000 : (i == 1) ? 16'h7fff : 16'($urandom),
                      '0, 1'b0);
      send_command(CMD_FORWARD, 0, 16'h8000, 16'h0, 1'b0);
      send_command(CMD_FORWARD, 1, 16'h7fff, 16'h0, 1'b1);
      send_command(CMD_FORWARD, 0, 16'h7fff, 16'h0, 1'b1);
      send_command(CMD_FORWARD, 0, 16'h8000, 16'h0, 1'b1);
      send_command(CMD_TARGET, 0, 16'h8000, 16'h0, 1'b0);
      send_command(CMD_TARGET, 63, 16'h7fff, 16'hffff, 1'b1);
      send_command(CMD_HIDDEN, 5, 16'h7fff, 16'h7fff, 1'b0);
      send_command(CMD_FORWARD, 2, 16'h1000, 16'h0, 1'b0);
      send_command(CMD_HIDDEN, 6, 16'h8000, 16'h8000, 1'b1);
      send_command(CMD_UPDATE, 0, 16'h8000, 16'h0, 1'b0);
      send_command(CMD_UPDATE, 1, 16'h7fff, 16'h0, 1'b1);
      send_command(CMD_UPDATE, 63, 16'h0, 16'h0, 1'b0);
      send_command(3'd5, 0, 16'h1234, 16'h0, 1'b1);
      send_command(3'd7, 63, 16'hffff, 16'hffff, 1'b0);
      // random phases under several rate settings
      for (int p = 0; p < 4; p++) begin
         write_register(CSR_LEARNING_RATE, rates[p]);
         write_register(CSR_MOMENTUM, moms[p]);
         send_idle_pct = phase_idle[p];
         stall_pct = phase_stall[p];
         for (int k = 0; k < 53; k++) begin
            if ($urandom_range(4) == 0) random_command();
            else training_step($urandom_range(1, 3));
         end
      end
      release_request();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
